// File: hw/rtl/pnect_pkg.sv
// Shared constants, types and counter-row helpers for the per-node event counter table.
package pnect_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int NUM_TYPES = 2;

  localparam int ID_W     = 16;
  localparam int CNT_W    = 8;
  localparam int TYPE_W   = 2;
  localparam int EPOCH_W  = 16;
  localparam int KIND_W   = 3;
  localparam int SLOT_W   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNTS_W   = NUM_TYPES * CNT_W;
  localparam int ROW_W    = ID_W + CNTS_W;

  localparam logic [CNT_W-1:0]  COUNT_MAX = 8'hff;
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(NUM_SLOTS - 1);

  typedef enum logic [KIND_W-1:0] {
    KIND_SATURATED = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_UNKNOWN   = 3'd2,
    KIND_ENTRY     = 3'd3,
    KIND_END       = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT
  } state_t;

  localparam logic ACT_TRACK = 1'b0;
  localparam logic ACT_DUMP  = 1'b1;

  // Pick the counter of one type out of a packed row of counters.
  function automatic logic [CNT_W-1:0] get_count(logic [CNTS_W-1:0] counts,
                                                 logic [TYPE_W-1:0] t);
    logic [CNT_W-1:0] c;
    c = '0;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (t == TYPE_W'(i)) c = counts[i*CNT_W +: CNT_W];
    end
    return c;
  endfunction

  // Replace the counter of one type in a packed row of counters.
  function automatic logic [CNTS_W-1:0] set_count(logic [CNTS_W-1:0] counts,
                                                  logic [TYPE_W-1:0] t,
                                                  logic [CNT_W-1:0] value);
    logic [CNTS_W-1:0] r;
    r = counts;
    for (int i = 0; i < NUM_TYPES; i++) begin
      if (t == TYPE_W'(i)) r[i*CNT_W +: CNT_W] = value;
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/pnect_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pnect_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/per_node_event_counter_table.sv
// Per-node event counter table: one row per slot holds a node ID and one counter per type.
// A request is taken only while the block is idle. A track request of a known type walks the
// slot rows one per cycle through the single read port of the row memory, stopping at the first
// matching ID; a track request hands over a report (saturated, table full, unknown type) when
// there is one. A dump request reads all NUM_SLOTS rows, one per cycle while no nonzero counter
// waits on a result stall, clearing and reporting each nonzero counter, then emits the end
// marker. A dump of an unknown type gives no result. Rows carry a valid bit cleared at reset,
// an invalid row reading as zero ID and zero counters, so the table is usable in the first
// cycle after reset with no clearing pass.
module per_node_event_counter_table (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [pnect_pkg::TYPE_W-1:0]  event_type,
  input  logic [pnect_pkg::ID_W-1:0]    node_id,
  input  logic [pnect_pkg::EPOCH_W-1:0] epoch,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [pnect_pkg::KIND_W-1:0]  kind,
  output logic [pnect_pkg::TYPE_W-1:0]  report_type,
  output logic [pnect_pkg::ID_W-1:0]    report_node,
  output logic [pnect_pkg::CNT_W-1:0]   report_count,
  output logic [pnect_pkg::EPOCH_W-1:0] report_epoch,
  output logic                          last
);

  pnect_pkg::state_t state, state_next;
  pnect_pkg::kind_t  pend_kind, pend_kind_next;

  logic                          action_q;
  logic [pnect_pkg::TYPE_W-1:0]  type_q;
  logic [pnect_pkg::ID_W-1:0]    node_q;
  logic [pnect_pkg::EPOCH_W-1:0] epoch_q;
  logic [pnect_pkg::SLOT_W-1:0]  slot;
  logic [pnect_pkg::SLOT_W-1:0]  empty_slot;
  logic                          have_empty;
  logic [pnect_pkg::NUM_SLOTS-1:0] slot_valid;

  logic                          rd_en;
  logic [pnect_pkg::SLOT_W-1:0]  rd_addr;
  logic [pnect_pkg::ROW_W-1:0]   rd_data;
  logic                          wr_en;
  logic [pnect_pkg::SLOT_W-1:0]  wr_addr;
  logic [pnect_pkg::ROW_W-1:0]   wr_data;

  logic                          out_load;
  pnect_pkg::kind_t              load_kind;
  logic [pnect_pkg::ID_W-1:0]    load_node;
  logic [pnect_pkg::CNT_W-1:0]   load_count;
  logic                          load_last;

  logic                          in_acc;
  logic                          in_type_ok;
  logic                          out_free;
  logic [pnect_pkg::ROW_W-1:0]   row;
  logic [pnect_pkg::ID_W-1:0]    row_id;
  logic [pnect_pkg::CNTS_W-1:0]  row_cnts;
  logic [pnect_pkg::CNT_W-1:0]   row_cnt;
  logic                          row_empty;
  logic                          at_last;
  logic                          is_track;
  logic                          hit;
  logic                          sat;
  logic                          claim_ok;
  logic                          dump_hit;
  logic                          advance;

  pnect_ram #(
    .WIDTH (pnect_pkg::ROW_W),
    .DEPTH (pnect_pkg::NUM_SLOTS)
  ) u_rows (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign in_stall   = (state != pnect_pkg::S_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign in_type_ok = ({1'b0, event_type} < 3'(pnect_pkg::NUM_TYPES));
  assign out_free   = !out_valid || !out_stall;

  // A row never written reads as all zero.
  assign row       = slot_valid[slot] ? rd_data : '0;
  assign row_id    = row[pnect_pkg::ROW_W-1 -: pnect_pkg::ID_W];
  assign row_cnts  = row[pnect_pkg::CNTS_W-1:0];
  assign row_cnt   = pnect_pkg::get_count(row_cnts, type_q);
  assign row_empty = (row_cnts == '0);
  assign at_last   = (slot == pnect_pkg::SLOT_LAST);
  assign is_track  = (action_q == pnect_pkg::ACT_TRACK);
  assign hit       = is_track && (row_id == node_q);
  assign sat       = (row_cnt == pnect_pkg::COUNT_MAX);
  assign claim_ok  = have_empty || row_empty;
  assign dump_hit  = !is_track && (row_cnt != '0);
  assign advance   = (state == pnect_pkg::S_SCAN) && !at_last && !hit &&
                     !(dump_hit && !out_free);

  // Next state
  always_comb begin
    state_next     = state;
    pend_kind_next = pend_kind;
    case (state)
      pnect_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_type_ok) begin
            state_next = pnect_pkg::S_SCAN;
          end else if (action == pnect_pkg::ACT_TRACK) begin
            state_next     = pnect_pkg::S_EMIT;
            pend_kind_next = pnect_pkg::KIND_UNKNOWN;
          end
        end
      end
      pnect_pkg::S_SCAN: begin
        if (is_track) begin
          if (hit) begin
            if (sat) begin
              state_next     = pnect_pkg::S_EMIT;
              pend_kind_next = pnect_pkg::KIND_SATURATED;
            end else begin
              state_next = pnect_pkg::S_IDLE;
            end
          end else if (at_last) begin
            if (claim_ok) begin
              state_next = pnect_pkg::S_IDLE;
            end else begin
              state_next     = pnect_pkg::S_EMIT;
              pend_kind_next = pnect_pkg::KIND_FULL;
            end
          end
        end else if (at_last && !(dump_hit && !out_free)) begin
          state_next     = pnect_pkg::S_EMIT;
          pend_kind_next = pnect_pkg::KIND_END;
        end
      end
      pnect_pkg::S_EMIT: begin
        if (out_free) state_next = pnect_pkg::S_IDLE;
      end
      default: state_next = pnect_pkg::S_IDLE;
    endcase
  end

  // Memory access and result load
  always_comb begin
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = slot;
    wr_data    = row;
    out_load   = 1'b0;
    load_kind  = pend_kind;
    load_node  = node_q;
    load_count = pnect_pkg::CNT_W'(1);
    load_last  = 1'b1;
    case (state)
      pnect_pkg::S_IDLE: begin
        rd_en = in_acc;
      end
      pnect_pkg::S_SCAN: begin
        rd_en   = advance;
        rd_addr = slot + 1'b1;
        if (is_track) begin
          if (hit) begin
            wr_en   = !sat;
            wr_data = {row_id, pnect_pkg::set_count(row_cnts, type_q, row_cnt + 1'b1)};
          end else if (at_last && claim_ok) begin
            wr_en   = 1'b1;
            wr_addr = have_empty ? empty_slot : slot;
            wr_data = {node_q, pnect_pkg::set_count('0, type_q, pnect_pkg::CNT_W'(1))};
          end
        end else if (dump_hit && out_free) begin
          wr_en      = 1'b1;
          wr_data    = {row_id, pnect_pkg::set_count(row_cnts, type_q, '0)};
          out_load   = 1'b1;
          load_kind  = pnect_pkg::KIND_ENTRY;
          load_node  = row_id;
          load_count = row_cnt;
          load_last  = 1'b0;
        end
      end
      pnect_pkg::S_EMIT: begin
        out_load = out_free;
        if (pend_kind == pnect_pkg::KIND_END) begin
          load_node  = '0;
          load_count = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pnect_pkg::S_IDLE;
      pend_kind  <= pnect_pkg::KIND_END;
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      pend_kind <= pend_kind_next;
      if (wr_en) slot_valid[wr_addr] <= 1'b1;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Request and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      action_q   <= action;
      type_q     <= event_type;
      node_q     <= node_id;
      epoch_q    <= epoch;
      slot       <= '0;
      have_empty <= 1'b0;
    end else if (state == pnect_pkg::S_SCAN) begin
      if (is_track && !have_empty && row_empty) begin
        have_empty <= 1'b1;
        empty_slot <= slot;
      end
      if (advance) slot <= slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      kind         <= load_kind;
      report_type  <= type_q;
      report_node  <= load_node;
      report_count <= load_count;
      report_epoch <= epoch_q;
      last         <= load_last;
    end
  end

  // The row memory is only written while slots are being walked.
  assert property (@(posedge clk) disable iff (rst) wr_en |-> state == pnect_pkg::S_SCAN)
    else $error("row write outside the slot walk");

  // A dump only ever clears counters.
  assert property (@(posedge clk) disable iff (rst)
    (wr_en && !is_track) |-> pnect_pkg::get_count(wr_data[pnect_pkg::CNTS_W-1:0], type_q) == '0)
    else $error("dump wrote a nonzero counter");

  // A track request of a known type cannot report in the cycle after it is taken.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && action == pnect_pkg::ACT_TRACK && in_type_ok) |=> !out_load)
    else $error("track reported before any slot was read");

  // A loaded result overwrites nothing still waiting downstream.
  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("result register overwritten while stalled");

endmodule

// File: dv/pnect_checker.sv
// Checker for the per-node event counter table: tracks requests, predicts reports, compares.
`timescale 1ns / 1ps

module pnect_checker (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic                          action,
  input  logic [pnect_pkg::TYPE_W-1:0]  event_type,
  input  logic [pnect_pkg::ID_W-1:0]    node_id,
  input  logic [pnect_pkg::EPOCH_W-1:0] epoch,

  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [pnect_pkg::KIND_W-1:0]  kind,
  input  logic [pnect_pkg::TYPE_W-1:0]  report_type,
  input  logic [pnect_pkg::ID_W-1:0]    report_node,
  input  logic [pnect_pkg::CNT_W-1:0]   report_count,
  input  logic [pnect_pkg::EPOCH_W-1:0] report_epoch,
  input  logic                          last,

  output int                            mismatches,
  output int                            pending
);

  localparam int SHOW_LIMIT = 10;

  typedef struct {
    pnect_pkg::kind_t              kind;
    logic [pnect_pkg::TYPE_W-1:0]  rtype;
    logic [pnect_pkg::ID_W-1:0]    node;
    logic [pnect_pkg::CNT_W-1:0]   count;
    logic [pnect_pkg::EPOCH_W-1:0] ep;
    logic                          is_last;
  } report_t;

  report_t                     reports_due[$];
  logic [pnect_pkg::ID_W-1:0]  slot_id  [pnect_pkg::NUM_SLOTS];
  logic [pnect_pkg::CNT_W-1:0] slot_cnt [pnect_pkg::NUM_SLOTS][pnect_pkg::NUM_TYPES];

  function automatic report_t make_report(pnect_pkg::kind_t k,
                                          logic [pnect_pkg::TYPE_W-1:0] t,
                                          logic [pnect_pkg::ID_W-1:0] node,
                                          logic [pnect_pkg::CNT_W-1:0] count,
                                          logic [pnect_pkg::EPOCH_W-1:0] ep,
                                          logic is_last);
    report_t r;
    r.kind    = k;
    r.rtype   = t;
    r.node    = node;
    r.count   = count;
    r.ep      = ep;
    r.is_last = is_last;
    return r;
  endfunction

  function automatic string describe(report_t r);
    return $sformatf("kind %0d type %0d node %h count %0d epoch %h last %0b",
                     r.kind, r.rtype, r.node, r.count, r.ep, r.is_last);
  endfunction

  // Update the counter table for one request and queue the reports it causes.
  task automatic tally_request(input logic act, input logic [pnect_pkg::TYPE_W-1:0] t,
                               input logic [pnect_pkg::ID_W-1:0] node,
                               input logic [pnect_pkg::EPOCH_W-1:0] ep);
    int  hit;
    int  free_slot;
    bit  empty;
    hit = -1;
    free_slot = -1;
    if (act == pnect_pkg::ACT_TRACK) begin
      if (int'(t) >= pnect_pkg::NUM_TYPES) begin
        reports_due.push_back(make_report(pnect_pkg::KIND_UNKNOWN, t, node, 8'd1, ep, 1'b1));
        return;
      end
      // every slot takes part in the ID search, idle ones included
      for (int s = 0; s < pnect_pkg::NUM_SLOTS; s++) begin
        if (hit < 0 && slot_id[s] == node) hit = s;
      end
      if (hit >= 0) begin
        if (slot_cnt[hit][t] != pnect_pkg::COUNT_MAX) begin
          slot_cnt[hit][t] = slot_cnt[hit][t] + 8'd1;
        end else begin
          reports_due.push_back(make_report(pnect_pkg::KIND_SATURATED, t, node, 8'd1, ep,
                                            1'b1));
        end
      end else begin
        for (int s = 0; s < pnect_pkg::NUM_SLOTS; s++) begin
          empty = 1'b1;
          for (int k = 0; k < pnect_pkg::NUM_TYPES; k++) begin
            if (slot_cnt[s][k] != '0) empty = 1'b0;
          end
          if (free_slot < 0 && empty) free_slot = s;
        end
        if (free_slot >= 0) begin
          slot_id[free_slot]     = node;
          slot_cnt[free_slot][t] = 8'd1;
        end else begin
          reports_due.push_back(make_report(pnect_pkg::KIND_FULL, t, node, 8'd1, ep, 1'b1));
        end
      end
    end else if (int'(t) < pnect_pkg::NUM_TYPES) begin
      for (int s = 0; s < pnect_pkg::NUM_SLOTS; s++) begin
        if (slot_cnt[s][t] != '0) begin
          reports_due.push_back(make_report(pnect_pkg::KIND_ENTRY, t, slot_id[s],
                                            slot_cnt[s][t], ep, 1'b0));
          slot_cnt[s][t] = '0;
        end
      end
      reports_due.push_back(make_report(pnect_pkg::KIND_END, t, '0, '0, ep, 1'b1));
    end
  endtask

  initial mismatches = 0;

  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst) begin
      reports_due.delete();
      for (int s = 0; s < pnect_pkg::NUM_SLOTS; s++) begin
        slot_id[s] = '0;
        for (int k = 0; k < pnect_pkg::NUM_TYPES; k++) slot_cnt[s][k] = '0;
      end
    end else begin
      // results first: a result at this edge never belongs to a request taken at it
      if (out_valid && !out_stall) begin
        got = make_report(pnect_pkg::kind_t'(kind), report_type, report_node, report_count,
                          report_epoch, last);
        if (reports_due.size() == 0) begin
          if (mismatches < SHOW_LIMIT) $display("unexpected result: %s", describe(got));
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          if (got.kind !== want.kind || got.rtype !== want.rtype || got.node !== want.node ||
              got.count !== want.count || got.ep !== want.ep ||
              got.is_last !== want.is_last) begin
            if (mismatches < SHOW_LIMIT) begin
              $display("mismatch at %0t: expected %s", $realtime, describe(want));
              $display("                  got      %s", describe(got));
            end
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) tally_request(action, event_type, node_id, epoch);
    end
    pending = reports_due.size();
  end

endmodule

// File: dv/tb_top.sv
// Top of the counter table testbench: clock, reset, request and stall stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;

  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 3000;
  localparam int TAIL_CYCLES     = 40;
  localparam int RANDOM_REQUESTS = 150;
  localparam int POOL_SIZE       = 24;

  typedef enum int {
    FLOW,
    LIGHT,
    HEAVY,
    EVERY_THIRD
  } stall_mode_t;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_stall;
  logic                          action;
  logic [pnect_pkg::TYPE_W-1:0]  event_type;
  logic [pnect_pkg::ID_W-1:0]    node_id;
  logic [pnect_pkg::EPOCH_W-1:0] epoch;
  logic                          out_valid;
  logic                          out_stall;
  logic [pnect_pkg::KIND_W-1:0]  kind;
  logic [pnect_pkg::TYPE_W-1:0]  report_type;
  logic [pnect_pkg::ID_W-1:0]    report_node;
  logic [pnect_pkg::CNT_W-1:0]   report_count;
  logic [pnect_pkg::EPOCH_W-1:0] report_epoch;
  logic                          last;

  int mismatches;
  int pending;
  bit hold_off_req;
  int burst_left;
  int idle_cycles;

  per_node_event_counter_table i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .event_type   (event_type),
    .node_id      (node_id),
    .epoch        (epoch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .report_type  (report_type),
    .report_node  (report_node),
    .report_count (report_count),
    .report_epoch (report_epoch),
    .last         (last)
  );

  pnect_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .action       (action),
    .event_type   (event_type),
    .node_id      (node_id),
    .epoch        (epoch),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .kind         (kind),
    .report_type  (report_type),
    .report_node  (report_node),
    .report_count (report_count),
    .report_epoch (report_epoch),
    .last         (last),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offer one request, hold it until taken, then maybe drop valid for a gap.
  task automatic offer_request(input logic act, input logic [pnect_pkg::TYPE_W-1:0] t,
                               input logic [pnect_pkg::ID_W-1:0] node,
                               input logic [pnect_pkg::EPOCH_W-1:0] ep);
    int gap;
    in_valid   <= 1'b1;
    action     <= act;
    event_type <= t;
    node_id    <= node;
    epoch      <= ep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 7);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic wait_for_reports();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  // Result side: shifting stall patterns, plus one long hold-off on request.
  initial begin : receiver
    stall_mode_t mode;
    int          mode_left;
    int          phase;
    out_stall = 1'b0;
    mode      = FLOW;
    mode_left = 0;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 64);
        end
        mode_left--;
        phase++;
        case (mode)
          FLOW:    out_stall <= 1'b0;
          LIGHT:   out_stall <= ($urandom_range(0, 9) < 3);
          HEAVY:   out_stall <= ($urandom_range(0, 9) < 7);
          default: out_stall <= (phase % 3 != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    logic [pnect_pkg::ID_W-1:0] pool [POOL_SIZE];
    int                         pick;
    rst          = 1'b1;
    in_valid     = 1'b0;
    action       = pnect_pkg::ACT_TRACK;
    event_type   = '0;
    node_id      = '0;
    epoch        = '0;
    hold_off_req = 1'b0;
    burst_left   = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // node 0 hits slot 0 straight after reset
    offer_request(pnect_pkg::ACT_TRACK, '0, 16'h0000, 16'h0000);
    offer_request(pnect_pkg::ACT_TRACK, pnect_pkg::TYPE_W'(pnect_pkg::NUM_TYPES), 16'hffff,
                  16'hffff);
    offer_request(pnect_pkg::ACT_TRACK, '1, 16'h8001, 16'h7ffe);
    offer_request(pnect_pkg::ACT_DUMP, '1, 16'h0000, 16'h8000);
    offer_request(pnect_pkg::ACT_DUMP, pnect_pkg::TYPE_W'(pnect_pkg::NUM_TYPES), 16'hffff,
                  16'h0001);
    // fill the remaining slots, then overflow the table
    for (int i = 1; i < pnect_pkg::NUM_SLOTS; i++) begin
      offer_request(pnect_pkg::ACT_TRACK, pnect_pkg::TYPE_W'(i % pnect_pkg::NUM_TYPES),
                    pnect_pkg::ID_W'(i * 32'h1111), pnect_pkg::EPOCH_W'($urandom));
    end
    offer_request(pnect_pkg::ACT_TRACK, pnect_pkg::TYPE_W'(pnect_pkg::NUM_TYPES - 1), 16'h5a5a,
                  pnect_pkg::EPOCH_W'($urandom));
    offer_request(pnect_pkg::ACT_TRACK, '0, 16'h1111, pnect_pkg::EPOCH_W'($urandom));
    for (int k = 0; k < pnect_pkg::NUM_TYPES; k++) begin
      offer_request(pnect_pkg::ACT_DUMP, pnect_pkg::TYPE_W'(k), '0,
                    pnect_pkg::EPOCH_W'($urandom));
    end
    offer_request(pnect_pkg::ACT_DUMP, '0, 16'hffff, pnect_pkg::EPOCH_W'($urandom));
    wait_for_reports();

    // drive one counter past its ceiling
    repeat (int'(pnect_pkg::COUNT_MAX) + 2) begin
      offer_request(pnect_pkg::ACT_TRACK, pnect_pkg::TYPE_W'(pnect_pkg::NUM_TYPES - 1),
                    16'hbeef, pnect_pkg::EPOCH_W'($urandom));
    end
    for (int k = 0; k < pnect_pkg::NUM_TYPES; k++) begin
      offer_request(pnect_pkg::ACT_DUMP, pnect_pkg::TYPE_W'(k), '0,
                    pnect_pkg::EPOCH_W'($urandom));
    end

    // more nodes than slots so that full reports and slot reuse both occur
    for (int i = 0; i < POOL_SIZE; i++) pool[i] = pnect_pkg::ID_W'($urandom);
    hold_off_req = 1'b1;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) begin
        offer_request(pnect_pkg::ACT_TRACK,
                      pnect_pkg::TYPE_W'($urandom_range(0, pnect_pkg::NUM_TYPES - 1)),
                      pool[$urandom_range(0, POOL_SIZE - 1)], pnect_pkg::EPOCH_W'($urandom));
      end else if (pick < 70) begin
        offer_request(pnect_pkg::ACT_TRACK,
                      pnect_pkg::TYPE_W'($urandom_range(0, pnect_pkg::NUM_TYPES - 1)),
                      pnect_pkg::ID_W'($urandom), pnect_pkg::EPOCH_W'($urandom));
      end else if (pick < 78) begin
        offer_request(pnect_pkg::ACT_TRACK,
                      pnect_pkg::TYPE_W'($urandom_range(pnect_pkg::NUM_TYPES, 3)),
                      pnect_pkg::ID_W'($urandom), pnect_pkg::EPOCH_W'($urandom));
      end else if (pick < 97) begin
        offer_request(pnect_pkg::ACT_DUMP,
                      pnect_pkg::TYPE_W'($urandom_range(0, pnect_pkg::NUM_TYPES - 1)),
                      pnect_pkg::ID_W'($urandom), pnect_pkg::EPOCH_W'($urandom));
      end else begin
        offer_request(pnect_pkg::ACT_DUMP,
                      pnect_pkg::TYPE_W'($urandom_range(pnect_pkg::NUM_TYPES, 3)),
                      pnect_pkg::ID_W'($urandom), pnect_pkg::EPOCH_W'($urandom));
      end
    end

    wait_for_reports();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/pnect_pkg.sv
hw/rtl/pnect_ram.sv
hw/rtl/per_node_event_counter_table.sv
dv/pnect_checker.sv
dv/tb_top.sv
